@@ hdl/sha1_pkg.sv @@
// Shared types, constants and control bundles of the SHA-1 digest unit.
`default_nettype none
package sha1_pkg;

  localparam int NUM_WORDS   = 5;
  localparam int SCHED_WORDS = 16;
  localparam int ROUNDS      = 80;

  localparam logic [6:0] LAST_ROUND    = 7'(ROUNDS - 1);
  localparam logic [5:0] LAST_BYTE_POS = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX = 3'(NUM_WORDS - 1);
  localparam logic [7:0] PAD_MARK      = 8'h80;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K_CH   = 32'h5A827999;
  localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
  localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_ADD,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    ST_CH,
    ST_PAR1,
    ST_MAJ,
    ST_PAR2
  } stage_t;

  typedef struct packed {
    logic       wr_en;
    logic [5:0] wr_pos;
    logic [7:0] wr_byte;
    logic       shift;
  } sched_ctl_t;

  typedef struct packed {
    logic   load;
    logic   step;
    stage_t stage;
  } round_ctl_t;

endpackage
`default_nettype wire

@@ hdl/sha1_sched.sv @@
// Block buffer of sixteen words that also runs the SHA-1 message schedule.
`default_nettype none
module sha1_sched (
  input  wire logic                clk,
  input  wire sha1_pkg::sched_ctl_t ctl,
  output logic [31:0]              w_cur
);
  import sha1_pkg::*;

  logic [31:0] w_r [SCHED_WORDS];
  logic [31:0] w_new;
  logic [31:0] w_mix;

  assign w_mix = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign w_cur = w_r[0];

  // Byte zero of a word is its most significant byte.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int i = 0; i < SCHED_WORDS - 1; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[SCHED_WORDS - 1] <= w_new;
    end else if (ctl.wr_en) begin
      w_r[ctl.wr_pos[5:2]][{~ctl.wr_pos[1:0], 3'b000} +: 8] <= ctl.wr_byte;
    end
  end

endmodule
`default_nettype wire

@@ hdl/sha1_round.sv @@
// Working variables a to e and the shared SHA-1 round unit.
`default_nettype none
module sha1_round (
  input  wire logic                clk,
  input  wire sha1_pkg::round_ctl_t ctl,
  input  wire logic [31:0]         w_cur,
  input  wire logic [31:0]         h0,
  input  wire logic [31:0]         h1,
  input  wire logic [31:0]         h2,
  input  wire logic [31:0]         h3,
  input  wire logic [31:0]         h4,
  output logic [31:0]              a_out,
  output logic [31:0]              b_out,
  output logic [31:0]              c_out,
  output logic [31:0]              d_out,
  output logic [31:0]              e_out
);
  import sha1_pkg::*;

  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;

  always_comb begin
    case (ctl.stage)
      ST_CH: begin
        f_val = (b_r & c_r) | (~b_r & d_r);
        k_val = K_CH;
      end
      ST_PAR1: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = K_PAR1;
      end
      ST_MAJ: begin
        f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
        k_val = K_MAJ;
      end
      ST_PAR2: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = K_PAR2;
      end
      default: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = K_PAR2;
      end
    endcase
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + w_cur;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r <= h0;
      b_r <= h1;
      c_r <= h2;
      d_r <= h3;
      e_r <= h4;
    end else if (ctl.step) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  assign a_out = a_r;
  assign b_out = b_r;
  assign c_out = c_r;
  assign d_out = d_r;
  assign e_out = e_r;

endmodule
`default_nettype wire

@@ hdl/sha1_message_digest_unit.sv @@
// Streaming SHA-1 hasher: byte intake, padding sequencer, chaining words and digest output.
// A byte that does not fill a block is simply stored; a byte that fills one starts
// 80 rounds on the shared round unit, then the fold into the chain.
// A last item adds one pad byte per cycle up to the block end, then 80 rounds and a fold per
// padding block (one or two of them), then five output transfers, one per digest word.
// Items are taken one at a time; in_stall is high after a block-filling or last item until
// that block is folded in or the fifth digest word is taken. Synchronous reset loads the IV.
`default_nettype none
module sha1_message_digest_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_has_byte,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  import sha1_pkg::*;

  // Sequencer state and bookkeeping registers.
  state_t      state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;            // bytes held in the current block
  logic [60:0] len_r, len_nxt;            // message length in bytes, wraps
  logic [5:0]  pad_pos_r, pad_pos_nxt;    // next byte written by the pad sequencer
  logic        mark_r, mark_nxt;          // the 0x80 byte has been written
  logic        len_ok_r, len_ok_nxt;      // this padding block has room for the length
  logic        last_pend_r, last_pend_nxt; // padding still owed after the compression
  logic        final_r, final_nxt;        // the compression running is the last one
  logic [6:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;

  // Chaining words h0 to h4.
  logic [31:0] h_r [NUM_WORDS];
  logic [31:0] h_nxt [NUM_WORDS];
  logic [31:0] iv [NUM_WORDS];

  sched_ctl_t  sched_ctl;
  round_ctl_t  round_ctl;
  logic [31:0] w_cur;
  logic [31:0] a_v, b_v, c_v, d_v, e_v;
  logic [63:0] bit_len;
  logic [7:0]  pad_byte;
  logic        in_xfer;

  assign iv[0] = IV0;
  assign iv[1] = IV1;
  assign iv[2] = IV2;
  assign iv[3] = IV3;
  assign iv[4] = IV4;

  // Input is taken only while idle, so every valid item in that state is a transfer.
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && (state_r == S_IDLE);

  // The length field is the byte count times eight, sent most significant byte first
  // in the last eight positions of the final block.
  assign bit_len = {len_r, 3'b000};

  always_comb begin
    if (!mark_r) begin
      pad_byte = PAD_MARK;
    end else if (len_ok_r && (pad_pos_r[5:3] == 3'b111)) begin
      pad_byte = bit_len[{~pad_pos_r[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_has_byte && (cnt_r == LAST_BYTE_POS)) begin
            state_nxt = S_COMP;
          end else if (in_last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (pad_pos_r == LAST_BYTE_POS) begin
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        if (rnd_r == LAST_ROUND) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        if (final_r) begin
          state_nxt = S_OUT;
        end else if (last_pend_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_stall && (idx_r == LAST_WORD_IDX)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control and register next values.
  always_comb begin
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    pad_pos_nxt   = pad_pos_r;
    mark_nxt      = mark_r;
    len_ok_nxt    = len_ok_r;
    last_pend_nxt = last_pend_r;
    final_nxt     = final_r;
    rnd_nxt       = rnd_r;
    idx_nxt       = idx_r;
    for (int i = 0; i < NUM_WORDS; i++) begin
      h_nxt[i] = h_r[i];
    end
    sched_ctl.wr_en   = 1'b0;
    sched_ctl.wr_pos  = cnt_r;
    sched_ctl.wr_byte = in_data_byte;
    sched_ctl.shift   = 1'b0;
    round_ctl.step    = 1'b0;
    // The working variables pick up the chain whenever a compression starts.
    round_ctl.load    = (state_nxt == S_COMP) && (state_r != S_COMP);
    if (rnd_r < 7'd20) begin
      round_ctl.stage = ST_CH;
    end else if (rnd_r < 7'd40) begin
      round_ctl.stage = ST_PAR1;
    end else if (rnd_r < 7'd60) begin
      round_ctl.stage = ST_MAJ;
    end else begin
      round_ctl.stage = ST_PAR2;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_has_byte) begin
            sched_ctl.wr_en = 1'b1;
            cnt_nxt         = cnt_r + 6'd1;
            len_nxt         = len_r + 61'd1;
          end
          // A last byte that fills the block leaves the whole padding for a fresh block.
          last_pend_nxt = in_last && in_has_byte && (cnt_r == LAST_BYTE_POS);
          pad_pos_nxt   = in_has_byte ? cnt_r + 6'd1 : cnt_r;
          mark_nxt      = 1'b0;
        end
      end
      S_PAD: begin
        sched_ctl.wr_en   = 1'b1;
        sched_ctl.wr_pos  = pad_pos_r;
        sched_ctl.wr_byte = pad_byte;
        pad_pos_nxt       = pad_pos_r + 6'd1;
        last_pend_nxt     = 1'b1;
        if (!mark_r) begin
          mark_nxt   = 1'b1;
          len_ok_nxt = (pad_pos_r[5:3] != 3'b111);
        end
        if (pad_pos_r == LAST_BYTE_POS) begin
          final_nxt = mark_r && len_ok_r;
        end
      end
      S_COMP: begin
        sched_ctl.shift = 1'b1;
        round_ctl.step  = 1'b1;
        rnd_nxt         = (rnd_r == LAST_ROUND) ? 7'd0 : rnd_r + 7'd1;
      end
      S_ADD: begin
        h_nxt[0] = h_r[0] + a_v;
        h_nxt[1] = h_r[1] + b_v;
        h_nxt[2] = h_r[2] + c_v;
        h_nxt[3] = h_r[3] + d_v;
        h_nxt[4] = h_r[4] + e_v;
        idx_nxt  = 3'd0;
        if (!final_r && last_pend_r) begin
          pad_pos_nxt = 6'd0;
          len_ok_nxt  = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_WORD_IDX) begin
            // Back to the reset state for the next message.
            for (int i = 0; i < NUM_WORDS; i++) begin
              h_nxt[i] = iv[i];
            end
            cnt_nxt       = 6'd0;
            len_nxt       = 61'd0;
            final_nxt     = 1'b0;
            last_pend_nxt = 1'b0;
            mark_nxt      = 1'b0;
            idx_nxt       = 3'd0;
          end
        end
      end
      default: begin
        final_nxt = final_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 6'd0;
      len_r       <= 61'd0;
      pad_pos_r   <= 6'd0;
      mark_r      <= 1'b0;
      len_ok_r    <= 1'b0;
      last_pend_r <= 1'b0;
      final_r     <= 1'b0;
      rnd_r       <= 7'd0;
      idx_r       <= 3'd0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        h_r[i] <= iv[i];
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      pad_pos_r   <= pad_pos_nxt;
      mark_r      <= mark_nxt;
      len_ok_r    <= len_ok_nxt;
      last_pend_r <= last_pend_nxt;
      final_r     <= final_nxt;
      rnd_r       <= rnd_nxt;
      idx_r       <= idx_nxt;
      for (int i = 0; i < NUM_WORDS; i++) begin
        h_r[i] <= h_nxt[i];
      end
    end
  end

  sha1_sched u_sched (
    .clk   (clk),
    .ctl   (sched_ctl),
    .w_cur (w_cur)
  );

  sha1_round u_round (
    .clk   (clk),
    .ctl   (round_ctl),
    .w_cur (w_cur),
    .h0    (h_r[0]),
    .h1    (h_r[1]),
    .h2    (h_r[2]),
    .h3    (h_r[3]),
    .h4    (h_r[4]),
    .a_out (a_v),
    .b_out (b_v),
    .c_out (c_v),
    .d_out (d_v),
    .e_out (e_v)
  );

  // Digest words come straight from the chaining registers, h0 first.
  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = h_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == LAST_WORD_IDX);

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the streaming SHA-1 digest unit, with a built-in SHA-1 predictor.
module testbench;

  // Standard SHA-1 initial chaining value and round constants, kept local so the
  // predictor stands apart from the design's own package.
  localparam logic [31:0] H_INIT0 = 32'h67452301;
  localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
  localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
  localparam logic [31:0] H_INIT3 = 32'h10325476;
  localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;
  localparam logic [31:0] K_ROUNDS_00_19 = 32'h5A827999;
  localparam logic [31:0] K_ROUNDS_20_39 = 32'h6ED9EBA1;
  localparam logic [31:0] K_ROUNDS_40_59 = 32'h8F1BBCDC;
  localparam logic [31:0] K_ROUNDS_60_79 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE       = 8'h80;
  localparam int          BLOCK_BYTES    = 64;
  localparam int          LENGTH_FIELD_AT = 56;
  localparam int          DIGEST_WORDS   = 5;
  localparam int          MAX_WAIT       = 15;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_has_byte;
  logic [7:0]  in_data_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha1_message_digest_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_has_byte     (in_has_byte),
    .in_data_byte    (in_data_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  // One expected digest word, in the order the unit must deliver them.
  typedef struct {
    logic [31:0] word;
    logic [2:0]  word_idx;
    logic        is_last;
  } digest_entry_t;

  digest_entry_t digest_words_due[$];
  digest_entry_t due;

  // Predictor state: chaining words, the partial block, its fill level and the
  // running message length in bytes (61 bits, so the bit length wraps at 2^64).
  logic [31:0] chain_h [0:DIGEST_WORDS-1];
  logic [7:0]  block_bytes [0:BLOCK_BYTES-1];
  int          block_fill;
  logic [60:0] msg_len_bytes;

  // Idle control for both sides. The receiver counts its stall cycles in its own
  // process; a long hold-off is requested through hold_request.
  bit tx_idle_on;
  bit rx_idle_on;
  int rx_wait_left;
  int hold_request;
  int hold_left;

  int mismatches;
  int digests_checked;
  int messages_hashed;
  int items_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the unit hangs; well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("** sha1_message_digest_unit: FAILED **");
    $finish;
  end

  // Predictor: return to the state right after reset.
  function automatic void sha1_clear_state();
    chain_h[0] = H_INIT0;
    chain_h[1] = H_INIT1;
    chain_h[2] = H_INIT2;
    chain_h[3] = H_INIT3;
    chain_h[4] = H_INIT4;
    for (int j = 0; j < BLOCK_BYTES; j++) block_bytes[j] = 8'h00;
    block_fill = 0;
    msg_len_bytes = '0;
  endfunction

  // One 80-round compression of block_bytes, folded into the chaining words.
  function automatic void sha1_compress_block();
    logic [31:0] w [0:79];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++)
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    for (int i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K_ROUNDS_00_19;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K_ROUNDS_20_39;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_ROUNDS_40_59;
      end else begin
        f = b ^ c ^ d;
        k = K_ROUNDS_60_79;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] = chain_h[0] + a;
    chain_h[1] = chain_h[1] + b;
    chain_h[2] = chain_h[2] + c;
    chain_h[3] = chain_h[3] + d;
    chain_h[4] = chain_h[4] + e;
  endfunction

  // Absorb one accepted input transfer. On a message end this pads the message,
  // runs the one or two closing compressions and queues the five digest words.
  function automatic void sha1_absorb_item(bit has_byte, logic [7:0] data_byte, bit is_end);
    int n;
    logic [63:0] bit_len;
    digest_entry_t entry;
    if (has_byte) begin
      block_bytes[block_fill] = data_byte;
      block_fill++;
      msg_len_bytes = msg_len_bytes + 61'd1;
      if (block_fill == BLOCK_BYTES) begin
        sha1_compress_block();
        block_fill = 0;
      end
    end
    if (!is_end) return;
    n = block_fill;
    block_bytes[n] = PAD_BYTE;
    for (int j = n + 1; j < BLOCK_BYTES; j++) block_bytes[j] = 8'h00;
    // With no room left for the length, the pad spills into a second block.
    if (n >= LENGTH_FIELD_AT) begin
      sha1_compress_block();
      for (int j = 0; j < BLOCK_BYTES; j++) block_bytes[j] = 8'h00;
    end
    bit_len = {msg_len_bytes, 3'b000};
    for (int j = 0; j < 8; j++) block_bytes[BLOCK_BYTES-1-j] = bit_len[8*j +: 8];
    sha1_compress_block();
    for (int j = 0; j < DIGEST_WORDS; j++) begin
      entry.word = chain_h[j];
      entry.word_idx = 3'(j);
      entry.is_last = (j == DIGEST_WORDS - 1);
      digest_words_due.push_back(entry);
    end
    sha1_clear_state();
  endfunction

  // Offer one item after a random gap and hold it until the unit takes it.
  // Inputs change only on the falling edge; acceptance is judged at the rising edge.
  task automatic send_item(bit has_byte, logic [7:0] data_byte, bit is_end);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_has_byte  <= has_byte;
    in_data_byte <= data_byte;
    in_last      <= is_end;
    do @(posedge clk); while (in_stall);
    sha1_absorb_item(has_byte, data_byte, is_end);
    if (has_byte || is_end) items_sent++;
    @(negedge clk);
  endtask

  // A whole message of random bytes. The end marker rides either on the final
  // byte or on a separate byte-less item; noise adds stray idle items.
  task automatic send_message(int len, bit end_on_byte, bit with_noise);
    for (int i = 0; i < len; i++) begin
      if (with_noise && $urandom_range(0, 15) == 0) send_item(1'b0, 8'($urandom), 1'b0);
      send_item(1'b1, 8'($urandom_range(0, 255)), end_on_byte && (i == len - 1));
    end
    if (len == 0 || !end_on_byte) send_item(1'b0, 8'($urandom), 1'b1);
    messages_hashed++;
  endtask

  // The sender goes quiet so the last item is not offered again, then waits for
  // every expected digest word.
  task automatic wait_for_digests();
    in_valid <= 1'b0;
    while (digest_words_due.size() > 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Directed cases: idle items, the empty message, byte extremes, and both ways
  // of marking the end of a message.
  task automatic test_directed_cases();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_item(1'b0, 8'hFF, 1'b0);
    send_item(1'b0, 8'h00, 1'b0);
    send_item(1'b0, 8'h00, 1'b1);
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b1, 8'hFF, 1'b0);
    send_item(1'b0, 8'hA5, 1'b1);
    send_item(1'b1, 8'h61, 1'b0);
    send_item(1'b1, 8'h62, 1'b0);
    send_item(1'b1, 8'h63, 1'b1);
    send_item(1'b1, 8'h80, 1'b1);
    send_item(1'b1, 8'h7F, 1'b0);
    send_item(1'b0, 8'h55, 1'b0);
    send_item(1'b1, 8'h01, 1'b1);
    messages_hashed += 5;
    wait_for_digests();
  endtask

  // Lengths around the block end: 55 bytes still fits the length field, 56 spills
  // the padding into a second block, and 64 ends exactly on a full block.
  task automatic test_padding_boundaries();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_message(55, 1'b1, 1'b0);
    send_message(56, 1'b0, 1'b0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_message(64, 1'b1, 1'b0);
    wait_for_digests();
  endtask

  // The receiver holds off for a long stretch while two messages follow each
  // other, so the unit must stall its input until the digest words drain.
  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    hold_request = 600;
    send_message(3, 1'b1, 1'b0);
    send_message(5, 1'b0, 1'b0);
    wait_for_digests();
  endtask

  // Mostly short messages, some spanning up to three blocks; idling switches on
  // and off between messages to get both busy and sparse traffic.
  task automatic test_random_messages(int byte_target);
    int bytes_done;
    int len;
    bytes_done = 0;
    while (bytes_done < byte_target) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) len = $urandom_range(0, 20);
      else len = $urandom_range(40, 130);
      send_message(len, 1'($urandom_range(0, 1)), 1'b1);
      bytes_done += len;
    end
    wait_for_digests();
  endtask

  // Receiver: out_stall follows the long hold-off first, then the per-word wait
  // drawn at each transfer, and is low otherwise.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_wait_left > 0) begin
        rx_wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker: every digest word transfer is matched against the oldest
  // expected word, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (digest_words_due.size() == 0) begin
        $error("digest word %h (index %0d) with no message pending", out_digest_word,
               out_word_index);
        mismatches++;
      end else begin
        due = digest_words_due.pop_front();
        if (out_digest_word !== due.word) begin
          $error("digest_word: expected %h, got %h", due.word, out_digest_word);
          mismatches++;
        end
        if (out_word_index !== due.word_idx) begin
          $error("word_index: expected %0d, got %0d", due.word_idx, out_word_index);
          mismatches++;
        end
        if (out_last_word !== due.is_last) begin
          $error("last_word: expected %0b, got %0b", due.is_last, out_last_word);
          mismatches++;
        end
        digests_checked++;
      end
      rx_wait_left = rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_has_byte  = 1'b0;
    in_data_byte = 8'h00;
    in_last      = 1'b0;
    mismatches   = 0;
    digests_checked = 0;
    messages_hashed = 0;
    items_sent   = 0;
    rx_wait_left = 0;
    hold_request = 0;
    hold_left    = 0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    sha1_clear_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_padding_boundaries();
    test_output_backpressure();
    test_random_messages(260);

    // Everything is accepted; let any stray digest words show up before the verdict.
    wait_for_digests();
    repeat (200) @(posedge clk);

    if (digest_words_due.size() > 0) begin
      $error("%0d digest words never arrived", digest_words_due.size());
      mismatches++;
    end
    $display("Hashed %0d messages from %0d input transfers; %0d digest words compared.",
             messages_hashed, items_sent, digests_checked);
    $display("Included empty messages, pad spill into a second block and output hold-off.");
    if (mismatches == 0) begin
      $display("** sha1_message_digest_unit: PASSED **");
    end else begin
      $display("** sha1_message_digest_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ sha1_message_digest_unit.f @@
hdl/sha1_pkg.sv
hdl/sha1_sched.sv
hdl/sha1_round.sv
hdl/sha1_message_digest_unit.sv
tb/testbench.sv
